// File: src/fifo_rbv_pkg.sv
package fifo_rbv_pkg;

  // Queue geometry
  localparam int DEPTH   = 16;
  localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;

  // Stream payload widths
  localparam int S_TDATA_W = 32;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 40;
  localparam int M_TUSER_W = 2;

  typedef enum logic [1:0] {
    MODE_ENQ    = 2'd0,
    MODE_DEQ    = 2'd1,
    MODE_REMOVE = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_e;

  // Map a position counted from the head to a physical memory address.
  function automatic logic [PTR_W-1:0] phys_addr(input logic [PTR_W-1:0] head,
                                                 input logic [CNT_W-1:0] idx);
    logic [CNT_W:0] sum;
    logic [CNT_W:0] lim;
    lim = (CNT_W + 1)'(DEPTH);
    sum = (CNT_W + 1)'(head) + (CNT_W + 1)'(idx);
    if (sum >= lim) begin
      sum = sum - lim;
    end
    return sum[PTR_W-1:0];
  endfunction

  // Fill level reduced to the width of the count field.
  function automatic logic [COUNT_W-1:0] count_field(input logic [CNT_W-1:0] fill);
    logic [CNT_W+COUNT_W-1:0] ext;
    ext = {{COUNT_W{1'b0}}, fill};
    return ext[COUNT_W-1:0];
  endfunction

endpackage

// File: src/fifo_with_remove_by_value.sv
// Sequence: enqueue writes its entry in the start state; dequeue reads the head entry there
//   and takes it in the dequeue state; remove-by-value reads one entry per scan step until a
//   match or the end, then moves each later entry down with one read and one write per entry,
//   overlapped in the same pass. An empty queue skips the scan. All end in the done state.
// Throughput: one operation at a time; input is taken only in the idle state, entered when the
//   done state loads the result into the output register; it waits while that register is full.
// Reset: head, fill level, sequencer and output register clear; entry memory is not cleared.
module fifo_with_remove_by_value (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [fifo_rbv_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // [31:0] value
  input  logic [fifo_rbv_pkg::S_TUSER_W-1:0]  s_axis_tuser,  // [1:0] mode
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [fifo_rbv_pkg::M_TDATA_W-1:0]  m_axis_tdata,  // [31:0] data, [36:32] count
  output logic [fifo_rbv_pkg::M_TUSER_W-1:0]  m_axis_tuser   // [1:0] status
);

  localparam int PTR_W   = fifo_rbv_pkg::PTR_W;
  localparam int CNT_W   = fifo_rbv_pkg::CNT_W;
  localparam int VALUE_W = fifo_rbv_pkg::VALUE_W;
  localparam int COUNT_W = fifo_rbv_pkg::COUNT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_DEQ,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_e;

  // Sequencer and queue control
  state_e                  state_q, state_d;
  logic [PTR_W-1:0]        head_q, head_d;
  logic [CNT_W-1:0]        fill_q, fill_d;
  logic [CNT_W-1:0]        rd_idx_q, rd_idx_d;   // position whose read is in flight
  logic [CNT_W-1:0]        rd_nxt;

  // Latched transaction and pending result
  logic [1:0]              mode_q;
  logic signed [VALUE_W-1:0] value_q;
  fifo_rbv_pkg::status_e   res_status_q, res_status_d;
  logic [VALUE_W-1:0]      res_data_q, res_data_d;

  // Output register
  logic                    out_valid_q;
  fifo_rbv_pkg::status_e   out_status_q;
  logic [VALUE_W-1:0]      out_data_q;
  logic [COUNT_W-1:0]      out_count_q;
  logic                    out_free;

  // Entry memory, one write and one registered read per cycle
  logic [VALUE_W-1:0]      entries_mem [fifo_rbv_pkg::DEPTH];
  logic [VALUE_W-1:0]      rd_data_q;
  logic [PTR_W-1:0]        rd_addr;
  logic [PTR_W-1:0]        wr_addr;
  logic [VALUE_W-1:0]      wr_data;
  logic                    wr_en;
  logic                    in_xact;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_xact       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign rd_nxt        = rd_idx_q + CNT_W'(1);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entries_mem[wr_addr] <= wr_data;
    end
    rd_data_q <= entries_mem[rd_addr];
  end

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    fill_d       = fill_q;
    rd_idx_d     = rd_idx_q;
    res_status_d = res_status_q;
    res_data_d   = res_data_q;
    rd_addr      = head_q;
    wr_addr      = fifo_rbv_pkg::phys_addr(head_q, fill_q);
    wr_data      = value_q;
    wr_en        = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_xact) begin
          state_d = S_START;
        end
      end

      S_START: begin
        // Read of the head entry is issued here for dequeue and remove.
        res_status_d = fifo_rbv_pkg::ST_OK;
        res_data_d   = '0;
        rd_idx_d     = '0;
        state_d      = S_DONE;
        unique case (mode_q)
          fifo_rbv_pkg::MODE_ENQ: begin
            if (fill_q == CNT_W'(fifo_rbv_pkg::DEPTH)) begin
              res_status_d = fifo_rbv_pkg::ST_OVERFLOW;
            end else begin
              wr_en  = 1'b1;
              fill_d = fill_q + CNT_W'(1);
            end
          end
          fifo_rbv_pkg::MODE_DEQ: begin
            if (fill_q == '0) begin
              res_status_d = fifo_rbv_pkg::ST_UNDERFLOW;
            end else begin
              state_d = S_DEQ;
            end
          end
          fifo_rbv_pkg::MODE_REMOVE: begin
            if (fill_q == '0) begin
              res_status_d = fifo_rbv_pkg::ST_NOT_FOUND;
            end else begin
              state_d = S_SCAN;
            end
          end
          default: ;
        endcase
      end

      S_DEQ: begin
        res_data_d = rd_data_q;
        head_d     = fifo_rbv_pkg::phys_addr(head_q, CNT_W'(1));
        fill_d     = fill_q - CNT_W'(1);
        state_d    = S_DONE;
      end

      S_SCAN: begin
        // Compare the entry read last cycle, prefetch the next one.
        rd_addr  = fifo_rbv_pkg::phys_addr(head_q, rd_nxt);
        rd_idx_d = rd_nxt;
        if (rd_data_q == value_q) begin
          state_d = S_SHIFT;
        end else if (rd_nxt == fill_q) begin
          res_status_d = fifo_rbv_pkg::ST_NOT_FOUND;
          state_d      = S_DONE;
        end
      end

      S_SHIFT: begin
        // Move each later entry down by one to close the gap.
        if (rd_idx_q >= fill_q) begin
          fill_d  = fill_q - CNT_W'(1);
          state_d = S_DONE;
        end else begin
          wr_en    = 1'b1;
          wr_addr  = fifo_rbv_pkg::phys_addr(head_q, rd_idx_q - CNT_W'(1));
          wr_data  = rd_data_q;
          rd_addr  = fifo_rbv_pkg::phys_addr(head_q, rd_nxt);
          rd_idx_d = rd_nxt;
        end
      end

      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      head_q       <= '0;
      fill_q       <= '0;
      rd_idx_q     <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= fifo_rbv_pkg::ST_OK;
      out_data_q   <= '0;
      out_count_q  <= '0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      fill_q   <= fill_d;
      rd_idx_q <= rd_idx_d;
      if (state_q == S_DONE && out_free) begin
        out_valid_q  <= 1'b1;
        out_status_q <= res_status_q;
        out_data_q   <= res_data_q;
        out_count_q  <= fifo_rbv_pkg::count_field(fill_q);
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_xact) begin
      mode_q  <= s_axis_tuser;
      value_q <= s_axis_tdata;
    end
    res_status_q <= res_status_d;
    res_data_q   <= res_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {{(fifo_rbv_pkg::M_TDATA_W - VALUE_W - COUNT_W){1'b0}},
                          out_count_q, out_data_q};

  // Checks
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(fifo_rbv_pkg::DEPTH))
    else $error("fill level above queue depth");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xact |=> state_q == S_START)
    else $error("accepted transaction did not start");

  a_underflow_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_status_q == fifo_rbv_pkg::ST_UNDERFLOW |->
      out_count_q == '0 && out_data_q == '0)
    else $error("underflow result with entries held or data");

  a_data_only_on_deq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_status_q != fifo_rbv_pkg::ST_OK |-> out_data_q == '0)
    else $error("nonzero data on failed operation");

  a_shift_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SHIFT |-> rd_idx_q <= fill_q && rd_idx_q != '0)
    else $error("compaction index out of range");

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

  // Mode code the block must treat as a no-op; the package enum leaves it unnamed.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam int CLK_HALF    = 6;
  localparam int RESET_CYCLES = 9;
  localparam int RANDOM_ITEMS = 1200;
  localparam int HOLD_CYCLES  = 400;
  // The limit leaves room for a correct run: a remove scans and compacts the queue, random idle
  // is added on both sides, and the one long hold-off stalls the sink.
  localparam int CYCLE_LIMIT  = 800000;
  localparam int DRAIN_CYCLES = 2 * fifo_rbv_pkg::DEPTH + 20;

  // One result of the queue, as the block reports it.
  typedef struct packed {
    fifo_rbv_pkg::status_e status;
    logic [31:0]           data;
    logic [4:0]            count;
  } op_outcome_t;

  logic clk_i;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [fifo_rbv_pkg::S_TDATA_W-1:0] s_axis_tdata;   // [31:0] value
  logic [fifo_rbv_pkg::S_TUSER_W-1:0] s_axis_tuser;   // [1:0] mode
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [fifo_rbv_pkg::M_TDATA_W-1:0] m_axis_tdata;   // [31:0] data, [36:32] count, [39:37] zero
  logic [fifo_rbv_pkg::M_TUSER_W-1:0] m_axis_tuser;   // [1:0] status

  // Shadow of the queue contents, head at index 0.
  logic [31:0] held_values[$];
  // Outcomes predicted for accepted transactions, oldest first.
  op_outcome_t pending_outcomes[$];

  int mismatch_count;
  int cycle_count;
  int sink_hold_cycles;   // long hold-off request, consumed by the sink process
  int sink_stall_left;
  bit src_gaps;           // insert idle cycles between source transactions
  bit sink_gaps;          // drop m_axis_tready at random

  fifo_with_remove_by_value dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // Watchdog: end the run if the traffic never drains.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Mostly back-to-back, sometimes a few cycles, rarely a long pause.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Sink side: honor a long hold-off first, then random stalls when enabled.
  always @(posedge clk_i) begin
    if (sink_hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      sink_hold_cycles <= sink_hold_cycles - 1;
    end else if (sink_stall_left > 0) begin
      m_axis_tready <= 1'b0;
      sink_stall_left <= sink_stall_left - 1;
    end else if (sink_gaps && $urandom_range(0, 99) < 25) begin
      m_axis_tready <= 1'b0;
      sink_stall_left <= pick_gap();
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic report_mismatch(input string what, input logic [39:0] got,
                                 input logic [39:0] want);
    $display("mismatch at cycle %0d: %s got 0x%0h, want 0x%0h", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  // Apply one operation to the shadow queue and return the outcome it must produce.
  function automatic op_outcome_t apply_queue_op(input logic [1:0] mode,
                                                 input logic [31:0] value);
    op_outcome_t res;
    int hit;
    res.status = fifo_rbv_pkg::ST_OK;
    res.data   = '0;
    hit        = -1;
    case (mode)
      fifo_rbv_pkg::MODE_ENQ: begin
        if (held_values.size() >= fifo_rbv_pkg::DEPTH) res.status = fifo_rbv_pkg::ST_OVERFLOW;
        else held_values.push_back(value);
      end
      fifo_rbv_pkg::MODE_DEQ: begin
        if (held_values.size() == 0) res.status = fifo_rbv_pkg::ST_UNDERFLOW;
        else res.data = held_values.pop_front();
      end
      fifo_rbv_pkg::MODE_REMOVE: begin
        // Search from the head; only the first match goes, order of the rest is kept.
        for (int i = 0; i < held_values.size() && hit < 0; i++) begin
          if (held_values[i] == value) hit = i;
        end
        if (hit < 0) res.status = fifo_rbv_pkg::ST_NOT_FOUND;
        else held_values.delete(hit);
      end
      default: ;
    endcase
    res.count = 5'(held_values.size());
    return res;
  endfunction

  // Offer one transaction and wait for the handshake. Called at a rising edge;
  // returns at the edge where the transaction was taken, with valid still high.
  task automatic send_op(input logic [1:0] mode, input logic [31:0] value);
    int gap;
    gap = src_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= value;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_outcomes.push_back(apply_queue_op(mode, value));
  endtask

  // Check each result transaction against the oldest prediction.
  always @(posedge clk_i) begin
    op_outcome_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch("unexpected result, tdata", m_axis_tdata, '0);
      end else begin
        want = pending_outcomes.pop_front();
        if (m_axis_tuser !== want.status)
          report_mismatch("status", 40'(m_axis_tuser), 40'(want.status));
        if (m_axis_tdata[31:0] !== want.data)
          report_mismatch("data", 40'(m_axis_tdata[31:0]), 40'(want.data));
        if (m_axis_tdata[36:32] !== want.count)
          report_mismatch("count", 40'(m_axis_tdata[36:32]), 40'(want.count));
        if (m_axis_tdata[39:37] !== 3'b000)
          report_mismatch("tdata padding", 40'(m_axis_tdata[39:37]), 40'(3'b000));
      end
    end
  end

  // Random value: mostly full 32-bit, with a pool of small values to create
  // duplicates and the corner values of the signed range.
  function automatic logic [31:0] random_value();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 20) return 32'($urandom_range(0, 7));
    if (roll < 28) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'hFFFF_FFFF;
        default: return 32'h0000_0000;
      endcase
    end
    return $urandom();
  endfunction

  // Search value for a remove: usually one that is held, at a random position.
  function automatic logic [31:0] search_value();
    if (held_values.size() > 0 && $urandom_range(0, 99) < 70)
      return held_values[$urandom_range(0, held_values.size() - 1)];
    return random_value();
  endfunction

  task automatic test_empty_queue();
    send_op(fifo_rbv_pkg::MODE_DEQ, 32'h0000_0000);     // underflow on empty
    send_op(fifo_rbv_pkg::MODE_REMOVE, 32'h0000_0000);  // remove from an empty queue
    send_op(MODE_UNUSED, 32'hFFFF_FFFF);                // unused mode, nothing changes
  endtask

  task automatic test_full_queue();
    logic [31:0] fill_vals[fifo_rbv_pkg::DEPTH];
    fill_vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0005, 32'hFFFF_FFFF,
                  32'h0000_0000, 32'h0000_0005, 32'hAAAA_AAAA, 32'h5555_5555,
                  32'h0000_0001, 32'h1234_5678, 32'hFEDC_BA98, 32'h0000_0005,
                  32'h8000_0001, 32'h7FFF_FFFE, 32'h0F0F_0F0F, 32'hC3C3_C3C3};
    foreach (fill_vals[i]) send_op(fifo_rbv_pkg::MODE_ENQ, fill_vals[i]);
    send_op(fifo_rbv_pkg::MODE_ENQ, 32'h0000_0042);     // overflow on full
    send_op(MODE_UNUSED, 32'h0000_0000);                // unused mode while full
    send_op(fifo_rbv_pkg::MODE_REMOVE, 32'h0000_0005);  // first of three duplicates only
    send_op(fifo_rbv_pkg::MODE_REMOVE, 32'hC3C3_C3C3);  // tail entry
    send_op(fifo_rbv_pkg::MODE_REMOVE, 32'h0000_0042);  // absent value
    send_op(fifo_rbv_pkg::MODE_DEQ, 32'h0000_0000);     // head is the most negative value
  endtask

  // Hold the sink off for a long stretch while the source keeps offering,
  // so the output register fills and the block stops taking input.
  task automatic test_output_backpressure();
    src_gaps = 1'b0;
    sink_hold_cycles = HOLD_CYCLES;
    repeat (30) begin
      case ($urandom_range(0, 3))
        0, 1: send_op(fifo_rbv_pkg::MODE_ENQ, random_value());
        2: send_op(fifo_rbv_pkg::MODE_REMOVE, search_value());
        default: send_op(fifo_rbv_pkg::MODE_DEQ, random_value());
      endcase
    end
  endtask

  // Phases that push the queue toward full, toward empty, or keep it mixed,
  // each with its own idle pattern on both sides.
  task automatic test_random_traffic(input int n_items);
    int sent;
    int phase_len;
    int kind;
    int roll;
    sent = 0;
    while (sent < n_items) begin
      phase_len = $urandom_range(20, 80);
      kind      = $urandom_range(0, 2);
      case ($urandom_range(0, 3))
        0: begin src_gaps = 1'b0; sink_gaps = 1'b0; end
        1: begin src_gaps = 1'b1; sink_gaps = 1'b0; end
        2: begin src_gaps = 1'b0; sink_gaps = 1'b1; end
        default: begin src_gaps = 1'b1; sink_gaps = 1'b1; end
      endcase
      for (int i = 0; i < phase_len && sent < n_items; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          send_op(MODE_UNUSED, random_value());
        end else if (kind == 0) begin        // fill
          if (roll < 72) send_op(fifo_rbv_pkg::MODE_ENQ, random_value());
          else if (roll < 82) send_op(fifo_rbv_pkg::MODE_DEQ, random_value());
          else send_op(fifo_rbv_pkg::MODE_REMOVE, search_value());
        end else if (kind == 1) begin        // drain
          if (roll < 18) send_op(fifo_rbv_pkg::MODE_ENQ, random_value());
          else if (roll < 65) send_op(fifo_rbv_pkg::MODE_DEQ, random_value());
          else send_op(fifo_rbv_pkg::MODE_REMOVE, search_value());
        end else begin                       // mixed
          if (roll < 43) send_op(fifo_rbv_pkg::MODE_ENQ, random_value());
          else if (roll < 70) send_op(fifo_rbv_pkg::MODE_DEQ, random_value());
          else send_op(fifo_rbv_pkg::MODE_REMOVE, search_value());
        end
        sent++;
      end
    end
  endtask

  initial begin
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    s_axis_tvalid    = 1'b0;
    s_axis_tdata     = '0;
    s_axis_tuser     = '0;
    m_axis_tready    = 1'b0;
    mismatch_count   = 0;
    cycle_count      = 0;
    sink_hold_cycles = 0;
    sink_stall_left  = 0;
    src_gaps         = 1'b1;
    sink_gaps        = 1'b1;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_queue();
    test_full_queue();
    test_output_backpressure();
    test_random_traffic(RANDOM_ITEMS);

    // Drop valid, drain the outstanding results, then allow for stragglers.
    s_axis_tvalid <= 1'b0;
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// File: sim.f
src/fifo_rbv_pkg.sv
src/fifo_with_remove_by_value.sv
sim/testbench.sv
